// File: rtl/afc_pkg.sv
// ----------------------------------------------------------------------------
// afc_pkg
// Shared types and constants of the alpha fade controller.
// ----------------------------------------------------------------------------
package afc_pkg;

    localparam int REQ_TYPE_W = 2;
    localparam int DURATION_W = 16;
    localparam int DELAY_W    = 16;
    localparam int ALPHA_W    = 8;

    localparam logic [ALPHA_W-1:0] FULL_ALPHA = 8'hFF;

    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_TICK     = 2'd0,
        REQ_FADE_IN  = 2'd1,
        REQ_FADE_OUT = 2'd2,
        REQ_SET      = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OUT      = 2'd0,
        ST_IN       = 2'd1,
        ST_FADE_IN  = 2'd2,
        ST_FADE_OUT = 2'd3
    } fade_state_t;

endpackage

// File: rtl/afc_req_if.sv
// ----------------------------------------------------------------------------
// afc_req_if
// Request channel of the alpha fade controller with valid/ready handshake.
// ----------------------------------------------------------------------------
interface afc_req_if;
    import afc_pkg::*;

    logic                  valid;
    logic                  ready;
    req_t                  req_type;
    logic [DURATION_W-1:0] duration;
    logic                  target_status;
    logic [DELAY_W-1:0]    delay;

    modport source (
        output valid,
        input  ready,
        output req_type,
        output duration,
        output target_status,
        output delay
    );

    modport sink (
        input  valid,
        output ready,
        input  req_type,
        input  duration,
        input  target_status,
        input  delay
    );

endinterface

// File: rtl/afc_rsp_if.sv
// ----------------------------------------------------------------------------
// afc_rsp_if
// Result channel of the alpha fade controller with valid/ready handshake.
// ----------------------------------------------------------------------------
interface afc_rsp_if;
    import afc_pkg::*;

    logic               valid;
    logic               ready;
    logic [ALPHA_W-1:0] alpha;
    fade_state_t        fade_state;
    logic               draw_fill;
    logic               accepted;

    modport source (
        output valid,
        input  ready,
        output alpha,
        output fade_state,
        output draw_fill,
        output accepted
    );

    modport sink (
        input  valid,
        output ready,
        input  alpha,
        input  fade_state,
        input  draw_fill,
        input  accepted
    );

endinterface

// File: rtl/afc_serial_div.sv
// ----------------------------------------------------------------------------
// afc_serial_div
// Restoring divider that retires one quotient bit per cycle. The high half
// of the dividend must be below the divisor, so the quotient fits W bits.
// ----------------------------------------------------------------------------
module afc_serial_div #(
    parameter int W = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] num_hi,
    input  logic [W-1:0] num_lo,
    input  logic [W-1:0] den,
    output logic         done,
    output logic [W-1:0] quo
);

    localparam int CW = $clog2(W);

    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  den_reg, den_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    logic [W:0] trial;
    logic [W:0] diff;
    logic       fits;

    assign trial = {rem_reg, quo_reg[W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = !diff[W];

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = num_hi;
            quo_next  = num_lo;
            den_next  = den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[W-1:0] : trial[W-1:0];
            quo_next = {quo_reg[W-2:0], fits};
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            quo_reg  <= '0;
            den_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            den_reg  <= den_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// File: rtl/alpha_fade_controller.sv
// ----------------------------------------------------------------------------
// alpha_fade_controller
// Linear fade ramp for an overlay alpha value with delayed status changes.
// ----------------------------------------------------------------------------
// A set or a refused start goes from the idle state straight to the done state, a
// tick that needs no division passes the tick state, an accepted start the divide
// state and a ramping tick both; the divide state waits on the bit-serial divider.
// A new word is taken in the cycle after the previous result enters the output
// register, which may still be waiting on its consumer.
// Reset: asynchronous, fully out with alpha 255, countdown disarmed, unlocked.
module alpha_fade_controller #(
    parameter int DURATION_BITS = 16,
    parameter int DELAY_BITS    = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    afc_req_if.sink    req,
    afc_rsp_if.source  rsp
);
    import afc_pkg::*;

    localparam int DB  = DURATION_BITS;
    localparam int CB  = DURATION_BITS + 1;
    localparam int DLB = DELAY_BITS;
    localparam int DCB = DELAY_BITS + 1;
    localparam int NW  = DURATION_BITS + ALPHA_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TICK,
        S_DIV,
        S_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic               lock_reg, lock_next;
    fade_state_t        status_reg, status_next;
    logic               pending_reg, pending_next;
    logic [DCB-1:0]     delay_cnt_reg, delay_cnt_next;
    logic [DB-1:0]      target_reg, target_next;
    logic [CB-1:0]      count_reg, count_next;
    logic [ALPHA_W-1:0] alpha_reg, alpha_next;
    req_t               req_reg, req_next;
    logic [DB-1:0]      dur_reg, dur_next;
    logic               fill_reg, fill_next;
    logic               acc_reg, acc_next;

    logic               out_valid_reg, out_valid_next;
    logic [ALPHA_W-1:0] out_alpha_reg, out_alpha_next;
    fade_state_t        out_state_reg, out_state_next;
    logic               out_fill_reg, out_fill_next;
    logic               out_acc_reg, out_acc_next;

    logic [DB-1:0]      dur_in;
    logic [DLB-1:0]     dly_in;
    logic [NW-1:0]      start_prod;
    logic [NW-1:0]      tick_prod;
    fade_state_t        st_cd;
    logic [ALPHA_W-1:0] ramp_alpha;

    logic               div_start;
    logic [DB-1:0]      div_hi;
    logic [DB-1:0]      div_lo;
    logic [DB-1:0]      div_den;
    logic               div_done;
    logic [DB-1:0]      div_quo;

    assign dur_in     = DB'(req.duration);
    assign dly_in     = DLB'(req.delay);
    assign start_prod = NW'(alpha_reg) * NW'(dur_in);
    assign tick_prod  = {count_reg[DB-1:0], 8'h00} - NW'(count_reg[DB-1:0]);
    assign ramp_alpha = (status_reg == ST_FADE_IN) ? FULL_ALPHA - div_quo[ALPHA_W-1:0]
                                                   : div_quo[ALPHA_W-1:0];

    always_comb
    begin
        if (state_reg == S_TICK)
        begin
            div_hi  = DB'(tick_prod[NW-1:DB]);
            div_lo  = tick_prod[DB-1:0];
            div_den = target_reg;
        end
        else
        begin
            div_hi  = DB'(start_prod[NW-1:DB]);
            div_lo  = start_prod[DB-1:0];
            div_den = DB'(FULL_ALPHA);
        end
    end

    always_comb
    begin
        st_cd          = status_reg;
        delay_cnt_next = delay_cnt_reg;
        if (!delay_cnt_reg[DLB])
        begin
            if (delay_cnt_reg == '0)
            begin
                st_cd          = fade_state_t'({1'b0, pending_reg});
                delay_cnt_next = '1;
            end
            else
            begin
                delay_cnt_next = delay_cnt_reg - DCB'(1);
            end
        end
    end

    afc_serial_div #(
        .W (DB)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num_hi (div_hi),
        .num_lo (div_lo),
        .den    (div_den),
        .done   (div_done),
        .quo    (div_quo)
    );

    logic [DCB-1:0] delay_upd;

    always_comb
    begin
        state_next     = state_reg;
        lock_next      = cfg_wr_en ? cfg_wr_data : lock_reg;
        status_next    = status_reg;
        pending_next   = pending_reg;
        delay_upd      = delay_cnt_reg;
        target_next    = target_reg;
        count_next     = count_reg;
        alpha_next     = alpha_reg;
        req_next       = req_reg;
        dur_next       = dur_reg;
        fill_next      = fill_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_alpha_next = out_alpha_reg;
        out_state_next = out_state_reg;
        out_fill_next  = out_fill_reg;
        out_acc_next   = out_acc_reg;
        div_start      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    req_next  = req.req_type;
                    fill_next = 1'b0;
                    acc_next  = 1'b0;
                    unique case (req.req_type)
                        REQ_TICK:
                        begin
                            delay_upd   = delay_cnt_next;
                            status_next = st_cd;
                            if ((st_cd == ST_FADE_IN || st_cd == ST_FADE_OUT)
                                && count_reg != '1)
                            begin
                                count_next = count_reg + CB'(1);
                            end
                            state_next = S_TICK;
                        end
                        REQ_FADE_IN, REQ_FADE_OUT:
                        begin
                            if (lock_reg)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                div_start  = 1'b1;
                                dur_next   = dur_in;
                                acc_next   = 1'b1;
                                state_next = S_DIV;
                            end
                        end
                        REQ_SET:
                        begin
                            pending_next = req.target_status;
                            if (dly_in != '0)
                            begin
                                delay_upd = DCB'(dly_in);
                            end
                            else
                            begin
                                status_next = fade_state_t'({1'b0, req.target_status});
                                delay_upd   = '0;
                            end
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_TICK:
            begin
                state_next = S_DONE;
                unique case (status_reg)
                    ST_IN:
                    begin
                        fill_next = 1'b0;
                    end
                    ST_OUT:
                    begin
                        alpha_next = FULL_ALPHA;
                        fill_next  = 1'b1;
                    end
                    ST_FADE_IN, ST_FADE_OUT:
                    begin
                        if (count_reg >= CB'(target_reg))
                        begin
                            if (status_reg == ST_FADE_IN)
                            begin
                                alpha_next  = '0;
                                status_next = ST_IN;
                                fill_next   = 1'b0;
                            end
                            else
                            begin
                                alpha_next  = FULL_ALPHA;
                                status_next = ST_OUT;
                                fill_next   = 1'b1;
                            end
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                endcase
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (req_reg == REQ_TICK)
                    begin
                        alpha_next = ramp_alpha;
                        fill_next  = (ramp_alpha != '0);
                    end
                    else
                    begin
                        target_next = dur_reg;
                        if (req_reg == REQ_FADE_IN)
                        begin
                            status_next = ST_FADE_IN;
                            count_next  = CB'(dur_reg - div_quo);
                        end
                        else
                        begin
                            status_next = ST_FADE_OUT;
                            count_next  = CB'(div_quo);
                        end
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_alpha_next = alpha_reg;
                    out_state_next = status_reg;
                    out_fill_next  = fill_reg;
                    out_acc_next   = acc_reg;
                    state_next     = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lock_reg      <= 1'b0;
            status_reg    <= ST_OUT;
            pending_reg   <= 1'b0;
            delay_cnt_reg <= '1;
            target_reg    <= '0;
            count_reg     <= '0;
            alpha_reg     <= FULL_ALPHA;
            req_reg       <= REQ_TICK;
            dur_reg       <= '0;
            fill_reg      <= 1'b0;
            acc_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_alpha_reg <= '0;
            out_state_reg <= ST_OUT;
            out_fill_reg  <= 1'b0;
            out_acc_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lock_reg      <= lock_next;
            status_reg    <= status_next;
            pending_reg   <= pending_next;
            delay_cnt_reg <= delay_upd;
            target_reg    <= target_next;
            count_reg     <= count_next;
            alpha_reg     <= alpha_next;
            req_reg       <= req_next;
            dur_reg       <= dur_next;
            fill_reg      <= fill_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
            out_alpha_reg <= out_alpha_next;
            out_state_reg <= out_state_next;
            out_fill_reg  <= out_fill_next;
            out_acc_reg   <= out_acc_next;
        end
    end

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.alpha      = out_alpha_reg;
    assign rsp.fade_state = out_state_reg;
    assign rsp.draw_fill  = out_fill_reg;
    assign rsp.accepted   = out_acc_reg;

endmodule

// File: rtl/afc_checker.sv
// ----------------------------------------------------------------------------
// afc_checker
// Port-level checks of the alpha fade controller, bound to the top level.
// ----------------------------------------------------------------------------
module afc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [7:0] alpha,
    input logic [1:0] fade_state,
    input logic       draw_fill,
    input logic       accepted
);
    import afc_pkg::*;

    // The controller works on one request at a time.
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready
    ) else $error("request taken while the previous one is in progress");

    a_rsp_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid
            && $stable({alpha, fade_state, draw_fill, accepted})
    ) else $error("result word changed while stalled");

    a_fill_consistent: assert property (
        @(posedge clk) disable iff (!rst_n)
        rsp_valid && draw_fill |-> alpha != 8'd0 && fade_state != ST_IN
    ) else $error("fill requested with a clear overlay");

    a_accept_fading: assert property (
        @(posedge clk) disable iff (!rst_n)
        rsp_valid && accepted |->
            (fade_state == ST_FADE_IN || fade_state == ST_FADE_OUT) && !draw_fill
    ) else $error("accepted start did not leave a fade in progress");

endmodule

bind alpha_fade_controller afc_checker u_afc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .alpha      (rsp.alpha),
    .fade_state (rsp.fade_state),
    .draw_fill  (rsp.draw_fill),
    .accepted   (rsp.accepted)
);
